>>> hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define RSS_ASSERT(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// Check that a condition implies a property in the following cycle.
`define RSS_ASSERT_NEXT(lbl, clk, rst, cond, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");

`endif

>>> hdl/rss_pkg.sv
package rss_pkg;

   localparam int MAX_RECORDS_DEF = 64;

   localparam logic [2:0] ACT_INSERT = 3'd0;
   localparam logic [2:0] ACT_SEARCH = 3'd1;
   localparam logic [2:0] ACT_SORT   = 3'd2;
   localparam logic [2:0] ACT_CLEAR  = 3'd3;
   localparam logic [2:0] ACT_READ   = 3'd4;

   localparam logic [2:0] OP_NOP    = 3'd0;
   localparam logic [2:0] OP_INSERT = 3'd1;
   localparam logic [2:0] OP_SEARCH = 3'd2;
   localparam logic [2:0] OP_SORT   = 3'd3;
   localparam logic [2:0] OP_CLEAR  = 3'd4;
   localparam logic [2:0] OP_READ   = 3'd5;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_MISS = 2'd2;

   typedef struct packed {
      logic [2:0]          action;
      logic signed [31:0]  record_id;
      logic signed [15:0]  record_grade;
      logic [5:0]          read_index;
   } req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic signed [31:0]  found_id;
      logic signed [15:0]  found_grade;
      logic [5:0]          found_position;
      logic [6:0]          record_count;
   } rsp_type;

   typedef struct packed {
      logic [2:0]          op;
      logic signed [31:0]  record_id;
      logic signed [15:0]  record_grade;
      logic [5:0]          read_index;
   } cmd_type;

   typedef struct packed {
      logic signed [31:0]  id;
      logic signed [15:0]  grade;
   } rec_type;

endpackage

>>> hdl/record_store_with_stable_sort.sv
// Insert, clear, unknown, empty or single-record sort, empty search and failed read answer from idle;
// read answers once the store read returns; search walks from the head to a match or the last record.
// Sort is a stable insertion sort: each record from the second on moves down past lower grades.
// Throughput: one command at a time in the back end; the store's single read port sets it.
// Reset: synchronous, active high; empties the store (count zero), queues flushed.
// Store contents stay undefined after reset; no clearing pass is run.
module record_store_with_stable_sort #(
   parameter int MAX_RECORDS = rss_pkg::MAX_RECORDS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  rss_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output rss_pkg::rsp_type rsp_data
);
   import rss_pkg::*;

   cmd_type cmd_data;
   rsp_type rsp_new;
   logic    cmd_valid;
   logic    cmd_pop;
   logic    rsp_push;
   logic    rsp_full;

   // Front end: accept each transfer and classify its action into a command queue.
   rss_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data)
   );

   // Back end: the record store and its insert, search, sort and read sequencer.
   // Records live in a ring addressed from a head pointer, so insert is one write.
   rss_back #(.MAX_RECORDS(MAX_RECORDS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data),
      .rsp_push  (rsp_push),
      .rsp_full  (rsp_full),
      .rsp_data  (rsp_new)
   );

   // Result queue: hold finished results until the consumer takes them.
   rss_queue #(.W($bits(rsp_type))) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .full  (rsp_full),
      .din   (rsp_new),
      .pop   (rsp_pop),
      .empty (rsp_empty),
      .dout  (rsp_data)
   );
endmodule

>>> hdl/rss_queue.sv
module rss_queue #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  logic [W-1:0] din,
   input  logic         pop,
   output logic         empty,
   output logic [W-1:0] dout
);
   logic [W-1:0] slot_ff [2];
   logic         wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         do_push, do_pop;

   assign full    = (cnt_ff == 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign dout    = slot_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_in  = do_push ? ~wr_ff : wr_ff;
      rd_in  = do_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         slot_ff[wr_ff] <= din;
      end
   end
endmodule

>>> hdl/rss_front.sv
module rss_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  rss_pkg::req_type req_data,
   output logic             cmd_valid,
   input  logic             cmd_pop,
   output rss_pkg::cmd_type cmd_data
);
   import rss_pkg::*;

   cmd_type cmd_dec;
   logic    cmd_empty;

   // Classify the action; unknown codes become a no-op.
   always_comb begin
      cmd_dec.record_id    = req_data.record_id;
      cmd_dec.record_grade = req_data.record_grade;
      cmd_dec.read_index   = req_data.read_index;
      case (req_data.action)
         ACT_INSERT: cmd_dec.op = OP_INSERT;
         ACT_SEARCH: cmd_dec.op = OP_SEARCH;
         ACT_SORT:   cmd_dec.op = OP_SORT;
         ACT_CLEAR:  cmd_dec.op = OP_CLEAR;
         ACT_READ:   cmd_dec.op = OP_READ;
         default:    cmd_dec.op = OP_NOP;
      endcase
   end

   rss_queue #(.W($bits(cmd_type))) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .full  (req_full),
      .din   (cmd_dec),
      .pop   (cmd_pop),
      .empty (cmd_empty),
      .dout  (cmd_data)
   );

   assign cmd_valid = !cmd_empty;
endmodule

>>> hdl/rss_back.sv
`include "assert_macros.svh"
module rss_back #(
   parameter int MAX_RECORDS = rss_pkg::MAX_RECORDS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_pop,
   input  rss_pkg::cmd_type cmd_data,
   output logic             rsp_push,
   input  logic             rsp_full,
   output rss_pkg::rsp_type rsp_data
);
   import rss_pkg::*;

   localparam int AW = $clog2(MAX_RECORDS);
   localparam int CW = $clog2(MAX_RECORDS + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_SRCH = 3'd2;
   localparam logic [2:0] S_SKEY = 3'd3;
   localparam logic [2:0] S_SCMP = 3'd4;
   localparam logic [2:0] S_SPUT = 3'd5;

   rec_type          store_ff [MAX_RECORDS];
   rec_type          rd_ff;
   logic [2:0]       state_ff, state_in;
   logic [AW-1:0]    head_ff, head_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [AW-1:0]    pos_ff, pos_in;
   logic [AW-1:0]    i_ff, i_in;
   rec_type          key_ff, key_in;
   logic             we;
   logic [AW-1:0]    wa, ra;
   rec_type          wd;
   logic [1:0]       res_status;
   rec_type          res_rec;
   logic [AW-1:0]    res_pos;
   logic [CW+5:0]    idx_ext;
   logic [AW+6:0]    pos_ext;
   logic [CW+6:0]    cnt_ext;

   // Map a position in the current order to a store address.
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [AW-1:0] p);
      logic [AW:0] s;
      s = {1'b0, h} + {1'b0, p};
      if (s >= (AW+1)'(MAX_RECORDS)) begin
         s = s - (AW+1)'(MAX_RECORDS);
      end
      return s[AW-1:0];
   endfunction

   assign idx_ext = {{CW{1'b0}}, cmd_data.read_index};

   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      pos_in     = pos_ff;
      i_in       = i_ff;
      key_in     = key_ff;
      cmd_pop    = 1'b0;
      we         = 1'b0;
      wa         = '0;
      wd         = key_ff;
      ra         = '0;
      rsp_push   = 1'b0;
      res_status = ST_OK;
      res_rec    = '0;
      res_pos    = '0;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid && !rsp_full) begin
               cmd_pop = 1'b1;
               case (cmd_data.op)
                  OP_INSERT: begin
                     rsp_push = 1'b1;
                     if (count_ff == CW'(MAX_RECORDS)) begin
                        res_status = ST_FULL;
                     end else begin
                        head_in  = (head_ff == '0) ? AW'(MAX_RECORDS - 1) : head_ff - 1'b1;
                        we       = 1'b1;
                        wa       = head_in;
                        wd.id    = cmd_data.record_id;
                        wd.grade = cmd_data.record_grade;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_SEARCH: begin
                     key_in.id = cmd_data.record_id;
                     if (count_ff == '0) begin
                        rsp_push   = 1'b1;
                        res_status = ST_MISS;
                     end else begin
                        pos_in   = '0;
                        ra       = head_ff;
                        state_in = S_SRCH;
                     end
                  end
                  OP_SORT: begin
                     if (count_ff < CW'(2)) begin
                        rsp_push = 1'b1;
                     end else begin
                        i_in     = AW'(1);
                        ra       = phys(head_ff, AW'(1));
                        state_in = S_SKEY;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     rsp_push = 1'b1;
                  end
                  OP_READ: begin
                     if (idx_ext < {{6{1'b0}}, count_ff}) begin
                        pos_in   = idx_ext[AW-1:0];
                        ra       = phys(head_ff, idx_ext[AW-1:0]);
                        state_in = S_READ;
                     end else begin
                        rsp_push   = 1'b1;
                        res_status = ST_MISS;
                     end
                  end
                  default: begin
                     rsp_push = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            rsp_push = 1'b1;
            res_rec  = rd_ff;
            res_pos  = pos_ff;
            state_in = S_IDLE;
         end
         S_SRCH: begin
            if (rd_ff.id == key_ff.id) begin
               rsp_push = 1'b1;
               res_rec  = rd_ff;
               res_pos  = pos_ff;
               state_in = S_IDLE;
            end else if (({1'b0, pos_ff} + 1'b1) == (AW+1)'(count_ff)) begin
               rsp_push   = 1'b1;
               res_status = ST_MISS;
               state_in   = S_IDLE;
            end else begin
               pos_in = pos_ff + 1'b1;
               ra     = phys(head_ff, pos_in);
            end
         end
         S_SKEY: begin
            key_in   = rd_ff;
            pos_in   = i_ff;
            ra       = phys(head_ff, i_ff - 1'b1);
            state_in = S_SCMP;
         end
         S_SCMP, S_SPUT: begin
            we = 1'b1;
            if (state_ff == S_SCMP && rd_ff.grade < key_ff.grade) begin
               // Move the lower grade one place on and keep walking down.
               wa     = phys(head_ff, pos_ff);
               wd     = rd_ff;
               pos_in = pos_ff - 1'b1;
               if (pos_ff == AW'(1)) begin
                  state_in = S_SPUT;
               end else begin
                  ra = phys(head_ff, pos_ff - AW'(2));
               end
            end else begin
               // Drop the key into its slot, then advance to the next one or finish after the last.
               wa = phys(head_ff, pos_ff);
               wd = key_ff;
               if (({1'b0, i_ff} + 1'b1) == (AW+1)'(count_ff)) begin
                  rsp_push = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  i_in     = i_ff + 1'b1;
                  ra       = phys(head_ff, i_in);
                  state_in = S_SKEY;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign pos_ext = {7'b0, res_pos};
   assign cnt_ext = {7'b0, count_in};

   always_comb begin
      rsp_data.status         = res_status;
      rsp_data.found_id       = res_rec.id;
      rsp_data.found_grade    = res_rec.grade;
      rsp_data.found_position = pos_ext[5:0];
      rsp_data.record_count   = cnt_ext[6:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
      pos_ff <= pos_in;
      i_ff   <= i_in;
      key_ff <= key_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[wa] <= wd;
      end
      rd_ff <= store_ff[ra];
   end

   `RSS_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(MAX_RECORDS))
   `RSS_ASSERT(a_push_room, clock, reset, !rsp_push || !rsp_full)
   `RSS_ASSERT(a_pop_idle, clock, reset, !cmd_pop || state_ff == S_IDLE)
   `RSS_ASSERT_NEXT(a_done_idle, clock, reset, rsp_push, state_ff == S_IDLE)
endmodule
